/* sv/pco2_pkg.sv */
// ----------------------------------------------------------------------------
// pco2_pkg
// Shared types and constants for the CO2 PWM averager: payload structs,
// register indexes, controller states and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package pco2_pkg;

   localparam int unsigned MAX_SAMPLES_DEF = 64;

   localparam int unsigned TS_W     = 32;
   localparam int unsigned HT_W     = 16;
   localparam int unsigned PPM_W    = 16;
   localparam int unsigned CNT_W    = 7;
   localparam int unsigned FS_W     = 14;
   localparam int unsigned OFF_W    = 15;
   localparam int unsigned OUT_W    = 18;
   localparam int unsigned CSR_AW   = 2;
   localparam int unsigned CSR_DW   = 16;
   localparam int unsigned PROD_W   = HT_W + FS_W;
   localparam int unsigned DIV_W    = 26;
   localparam int unsigned DVS_W    = 10;
   localparam int unsigned DCNT_W   = 5;
   localparam int unsigned RECIP_W  = 27;
   localparam int unsigned RECIP_SHIFT = 36;

   localparam logic [HT_W-1:0]    MIN_HIGH_MS  = HT_W'(2);
   // 2^36 / 1000 rounded up. The product shifted right by 36 is the exact
   // quotient by 1000 for every dividend below 2^26.
   localparam logic [RECIP_W-1:0] PPM_RECIP    = RECIP_W'(68719477);
   localparam logic [PROD_W:0]    ROUND_BIAS   = (PROD_W + 1)'(500);
   // Rounded products at or above this convert to more than 65535 ppm.
   localparam logic [PROD_W:0]    SAT_LIMIT    = (PROD_W + 1)'(65536000);
   localparam logic [PPM_W-1:0]   PPM_SAT      = '1;

   localparam logic [FS_W-1:0]    FULL_SCALE_RST  = FS_W'(5000);
   localparam logic [PPM_W-1:0]   MAX_VALID_RST   = PPM_W'(5000);
   localparam logic [CNT_W-1:0]   SAMPLES_RST     = CNT_W'(10);
   localparam logic [OFF_W-1:0]   OFFSET_RST      = '0;

   localparam logic OP_EDGE   = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   typedef enum logic [CSR_AW-1:0] {
      CSR_FULL_SCALE = 2'd0,
      CSR_MAX_VALID  = 2'd1,
      CSR_SAMPLES    = 2'd2,
      CSR_OFFSET     = 2'd3
   } csr_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_RND,
      ST_SCALE,
      ST_ACC,
      ST_ALOAD,
      ST_ADIV,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic            op;
      logic            pwm_level;
      logic [TS_W-1:0] timestamp_ms;
   } req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] co2_ppm;
      logic [CNT_W-1:0]        accepted_samples;
   } rsp_type;

   typedef struct packed {
      logic edge_en;
      logic mul_en;
      logic rnd_load;
      logic scale_en;
      logic div_step;
      logic acc_en;
      logic adiv_load;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic div_last;
      logic reading_done;
      logic out_free;
   } status_type;

endpackage

/* sv/pwm_co2_sensor_averager.sv */
// ----------------------------------------------------------------------------
// pwm_co2_sensor_averager
// Decodes the PWM high time of a CO2 sensor into ppm and averages readings.
// ----------------------------------------------------------------------------
// Requests arrive on req_valid/req_stall with req_data. An edge request
// (op 0) records the rise time on a high level or the high time on a low
// level. A sample request (op 1) converts the stored high time to ppm and
// folds it into the running average; it occupies the block through the
// accepting state, then multiply, round, scale by the reciprocal of 1000
// and accumulate. req_stall is high while a request is being worked on.
// When the sample completes a reading, a 26-step serial divider forms sum
// / count, and the reading (average plus offset, and the number of
// accepted samples) is loaded into the result register driven on
// rsp_valid/rsp_data. Results leave one at a time; while the receiver
// holds rsp_stall the result stays put, and a further finished reading
// waits in the sequencer, with req_stall held high, until the register
// frees. Write configuration registers through csr_we/csr_index/csr_wdata
// only while the block is idle; the block does not enforce this. Reset is
// synchronous: it restores register defaults and clears the sequencer.
// ----------------------------------------------------------------------------
module pwm_co2_sensor_averager #(
   parameter int unsigned MAX_SAMPLES = pco2_pkg::MAX_SAMPLES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [pco2_pkg::CSR_AW-1:0]  csr_index,
   input  logic [pco2_pkg::CSR_DW-1:0]  csr_wdata,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  pco2_pkg::req_type            req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output pco2_pkg::rsp_type            rsp_data
);

   pco2_pkg::cmd_type    cmd;
   pco2_pkg::status_type status;

   pco2_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_data.op),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   pco2_dp #(
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

/* sv/pco2_ctrl.sv */
// ----------------------------------------------------------------------------
// pco2_ctrl
// Sequencer for the averager: accepts one request at a time, captures edges
// and steps samples through multiply, round, scale, accumulate and output.
// ----------------------------------------------------------------------------
module pco2_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_op,
   output logic                  req_stall,
   input  pco2_pkg::status_type  status,
   output pco2_pkg::cmd_type     cmd
);

   pco2_pkg::state_type state_ff;
   pco2_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pco2_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         pco2_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_op == pco2_pkg::OP_SAMPLE) begin
                  state_in = pco2_pkg::ST_MUL;
               end else begin
                  cmd.edge_en = 1'b1;
               end
            end
         end
         pco2_pkg::ST_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = pco2_pkg::ST_RND;
         end
         pco2_pkg::ST_RND: begin
            cmd.rnd_load = 1'b1;
            state_in     = pco2_pkg::ST_SCALE;
         end
         pco2_pkg::ST_SCALE: begin
            cmd.scale_en = 1'b1;
            state_in     = pco2_pkg::ST_ACC;
         end
         pco2_pkg::ST_ACC: begin
            cmd.acc_en = 1'b1;
            state_in   = status.reading_done ? pco2_pkg::ST_ALOAD : pco2_pkg::ST_IDLE;
         end
         pco2_pkg::ST_ALOAD: begin
            cmd.adiv_load = 1'b1;
            state_in      = pco2_pkg::ST_ADIV;
         end
         pco2_pkg::ST_ADIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = pco2_pkg::ST_OUT;
            end
         end
         pco2_pkg::ST_OUT: begin
            // Hold the finished reading until the result register is free.
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = pco2_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pco2_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

/* sv/pco2_dp.sv */
// ----------------------------------------------------------------------------
// pco2_dp
// Datapath: configuration registers, PWM edge capture, ppm conversion by
// reciprocal multiplication, the sample accumulator, a restoring divider for
// the average and the result register.
// ----------------------------------------------------------------------------
module pco2_dp #(
   parameter int unsigned MAX_SAMPLES = pco2_pkg::MAX_SAMPLES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [pco2_pkg::CSR_AW-1:0]       csr_index,
   input  logic [pco2_pkg::CSR_DW-1:0]       csr_wdata,
   input  pco2_pkg::req_type                 req_data,
   input  logic                              rsp_stall,
   output logic                              rsp_valid,
   output pco2_pkg::rsp_type                 rsp_data,
   input  pco2_pkg::cmd_type                 cmd,
   output pco2_pkg::status_type              status
);

   localparam int unsigned CNT_W   = pco2_pkg::CNT_W;
   localparam int unsigned PPM_W   = pco2_pkg::PPM_W;
   localparam int unsigned DIV_W   = pco2_pkg::DIV_W;
   localparam int unsigned DVS_W   = pco2_pkg::DVS_W;
   localparam int unsigned PROD_W  = pco2_pkg::PROD_W;
   localparam int unsigned OUT_W   = pco2_pkg::OUT_W;
   localparam int unsigned MUL_W   = DIV_W + pco2_pkg::RECIP_W;
   // The sample count register is 7 bits wide, so it never exceeds 127.
   localparam int unsigned CNT_MAX = (MAX_SAMPLES < 127) ? MAX_SAMPLES : 127;
   localparam int unsigned SUM_W   = PPM_W + $clog2(CNT_MAX);
   localparam logic [CNT_W-1:0] CNT_MAX_V = CNT_W'(CNT_MAX);

   // Configuration registers
   logic [pco2_pkg::FS_W-1:0]  full_scale_ff;
   logic [PPM_W-1:0]           max_valid_ff;
   logic [CNT_W-1:0]           samples_ff;
   logic [pco2_pkg::OFF_W-1:0] offset_ff;

   // Measurement state
   logic [pco2_pkg::TS_W-1:0]  rise_time_ff;
   logic [pco2_pkg::HT_W-1:0]  last_high_ff;
   logic [SUM_W-1:0]           sum_ff;
   logic [CNT_W-1:0]           valid_cnt_ff;
   logic [CNT_W-1:0]           taken_ff;

   // Conversion and divider
   logic [PROD_W-1:0]          prod_ff;
   logic [PROD_W-1:0]          prod_in;
   logic                       sat_ff;
   logic                       zero_ff;
   logic [DIV_W-1:0]           quo_ff;
   logic [DVS_W-1:0]           rem_ff;
   logic [DVS_W-1:0]           dvs_ff;
   logic [pco2_pkg::DCNT_W-1:0] dcnt_ff;

   logic                       rsp_valid_ff;
   pco2_pkg::rsp_type          rsp_data_ff;

   logic [pco2_pkg::HT_W-1:0]  t_adj;
   logic [PROD_W:0]            round_v;
   logic [MUL_W-1:0]           scaled;
   logic [DVS_W:0]             shifted;
   logic                       ge;
   logic [DVS_W:0]             diff;
   logic [PPM_W-1:0]           ppm;
   logic [CNT_W-1:0]           target;
   logic [CNT_W:0]             taken_next;
   logic [PPM_W-1:0]           avg;
   logic [OUT_W-1:0]           sum_out;

   always_comb begin
      t_adj   = (last_high_ff < pco2_pkg::MIN_HIGH_MS) ? '0
                                                       : last_high_ff - pco2_pkg::MIN_HIGH_MS;
      prod_in = PROD_W'(t_adj) * PROD_W'(full_scale_ff);
      round_v = {1'b0, prod_ff} + pco2_pkg::ROUND_BIAS;
      scaled  = MUL_W'(quo_ff) * MUL_W'(pco2_pkg::PPM_RECIP);
      shifted = {rem_ff, quo_ff[DIV_W-1]};
      ge      = (shifted >= {1'b0, dvs_ff});
      diff    = shifted - {1'b0, dvs_ff};
      ppm     = sat_ff ? pco2_pkg::PPM_SAT : quo_ff[PPM_W-1:0];
      if (samples_ff == '0) begin
         target = CNT_W'(1);
      end else if (samples_ff > CNT_MAX_V) begin
         target = CNT_MAX_V;
      end else begin
         target = samples_ff;
      end
      taken_next = {1'b0, taken_ff} + (CNT_W + 1)'(1);
      avg        = zero_ff ? '0 : quo_ff[PPM_W-1:0];
      sum_out    = OUT_W'(avg) + OUT_W'(signed'(offset_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_scale_ff <= pco2_pkg::FULL_SCALE_RST;
         max_valid_ff  <= pco2_pkg::MAX_VALID_RST;
         samples_ff    <= pco2_pkg::SAMPLES_RST;
         offset_ff     <= pco2_pkg::OFFSET_RST;
      end else if (csr_we) begin
         unique case (pco2_pkg::csr_idx_type'(csr_index))
            pco2_pkg::CSR_FULL_SCALE: full_scale_ff <= csr_wdata[pco2_pkg::FS_W-1:0];
            pco2_pkg::CSR_MAX_VALID:  max_valid_ff  <= csr_wdata[PPM_W-1:0];
            pco2_pkg::CSR_SAMPLES:    samples_ff    <= csr_wdata[CNT_W-1:0];
            pco2_pkg::CSR_OFFSET:     offset_ff     <= csr_wdata[pco2_pkg::OFF_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rise_time_ff <= '0;
         last_high_ff <= '0;
      end else if (cmd.edge_en) begin
         if (req_data.pwm_level) begin
            rise_time_ff <= req_data.timestamp_ms;
         end else begin
            last_high_ff <= pco2_pkg::HT_W'(req_data.timestamp_ms - rise_time_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         valid_cnt_ff <= '0;
         taken_ff     <= '0;
      end else if (cmd.acc_en) begin
         if (ppm < max_valid_ff) begin
            sum_ff       <= sum_ff + SUM_W'(ppm);
            valid_cnt_ff <= valid_cnt_ff + CNT_W'(1);
         end
         taken_ff <= taken_next[CNT_W-1:0];
      end else if (cmd.out_load) begin
         sum_ff       <= '0;
         valid_cnt_ff <= '0;
         taken_ff     <= '0;
      end
   end

   // The rounded product is divided by 1000 through the reciprocal in one
   // step. The restoring divider, one quotient bit per cycle, forms the
   // final sum / count average.
   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
      if (cmd.rnd_load) begin
         quo_ff  <= round_v[DIV_W-1:0];
         sat_ff  <= (round_v >= pco2_pkg::SAT_LIMIT);
      end else if (cmd.scale_en) begin
         quo_ff  <= DIV_W'(scaled[pco2_pkg::RECIP_SHIFT +: PPM_W]);
      end else if (cmd.adiv_load) begin
         quo_ff  <= DIV_W'(sum_ff);
         rem_ff  <= '0;
         dvs_ff  <= DVS_W'(valid_cnt_ff);
         dcnt_ff <= pco2_pkg::DCNT_W'(DIV_W);
         zero_ff <= (valid_cnt_ff == '0);
      end else if (cmd.div_step) begin
         rem_ff  <= ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
         quo_ff  <= {quo_ff[DIV_W-2:0], ge};
         dcnt_ff <= dcnt_ff - pco2_pkg::DCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff.co2_ppm          <= signed'(sum_out);
         rsp_data_ff.accepted_samples <= valid_cnt_ff;
      end
   end

   assign status.div_last     = (dcnt_ff == pco2_pkg::DCNT_W'(1));
   assign status.reading_done = (taken_next >= {1'b0, target});
   assign status.out_free     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_data            = rsp_data_ff;

endmodule
